// File: rtl/core/ksm_pkg.sv
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared sizes, command and status codes, and types of the keyed score table.
// ----------------------------------------------------------------------------
`default_nettype none

package ksm_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 16;
    localparam int SCORE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    localparam int IN_BITS    = CMD_W + 2 * KEY_BITS + SCORE_BITS;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = KEY_BITS + SCORE_BITS + CNT_W + 1 + STATUS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_ERASE   = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_POP     = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [SCORE_BITS-1:0] score;
    } t_entry;

    typedef struct packed {
        logic eq_key;
        logic eq_new_key;
        logic beats_best;
    } t_cmp;

endpackage

`default_nettype wire

// File: rtl/core/ksm_mem.sv
// ----------------------------------------------------------------------------
// ksm_mem
// Key and score storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic [ksm_pkg::IDX_W-1:0] i_wr_addr,
    input  wire ksm_pkg::t_entry           i_wr_data,
    input  wire logic [ksm_pkg::IDX_W-1:0] i_rd_addr,
    output ksm_pkg::t_entry                o_rd_data
);

    ksm_pkg::t_entry r_mem [ksm_pkg::DEPTH];
    ksm_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/ksm_cmp.sv
// ----------------------------------------------------------------------------
// ksm_cmp
// Shared compare unit: key match for the search pass, rank test for rescan.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_cmp (
    input  wire ksm_pkg::t_entry              i_entry,
    input  wire logic [ksm_pkg::KEY_BITS-1:0] i_key,
    input  wire logic [ksm_pkg::KEY_BITS-1:0] i_new_key,
    input  wire ksm_pkg::t_entry              i_best,
    output ksm_pkg::t_cmp                     o_res
);

    // higher score wins, equal scores go to the lower key
    logic [ksm_pkg::SCORE_BITS+ksm_pkg::KEY_BITS-1:0] w_rank_entry;
    logic [ksm_pkg::SCORE_BITS+ksm_pkg::KEY_BITS-1:0] w_rank_best;

    assign w_rank_entry = {i_entry.score, ~i_entry.key};
    assign w_rank_best  = {i_best.score, ~i_best.key};

    assign o_res.eq_key     = (i_entry.key == i_key);
    assign o_res.eq_new_key = (i_entry.key == i_new_key);
    assign o_res.beats_best = (w_rank_entry > w_rank_best);

endmodule

`default_nettype wire

// File: rtl/core/keyed_score_table_with_max.sv
// ----------------------------------------------------------------------------
// keyed_score_table_with_max
// Key/score table with a tracked top entry, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Each command beat is searched against all DEPTH entries through the single
// read port of the entry memory, one entry per cycle, then applied in the
// S_APPLY state. A pop, an erase of the top entry, an insert on the top's key,
// or a replace of the top's key that does not raise the top score walks the
// table once more to find the new top. s_axis_tready is high only between
// commands; a finished result waits in the output register while the next
// command is accepted. Entries hold no reset value; only valid entries are
// ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_score_table_with_max (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // cmd, key, new_key, score, zero pad
    input  wire logic [ksm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // top_key, top_score, entry_count, is_empty, status
    output logic [ksm_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

    localparam int KB = ksm_pkg::KEY_BITS;
    localparam int SB = ksm_pkg::SCORE_BITS;
    localparam int IW = ksm_pkg::IDX_W;
    localparam int CW = ksm_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_RESCAN,
        S_DONE
    } t_state;

    // control
    t_state                     r_state,      n_state;
    logic [IW:0]                r_idx,        n_idx;
    logic                       r_live,       n_live;
    logic [ksm_pkg::DEPTH-1:0]  r_valid,      n_valid;
    logic [CW-1:0]              r_count,      n_count;
    logic                       r_top_valid,  n_top_valid;
    logic [IW-1:0]              r_top_idx,    n_top_idx;
    logic                       r_hit_k,      n_hit_k;
    logic                       r_hit_nk,     n_hit_nk;
    logic                       r_free_hit,   n_free_hit;
    logic                       r_best_found, n_best_found;
    logic                       r_out_valid,  n_out_valid;

    // payload
    ksm_pkg::t_cmd              r_cmd,        n_cmd;
    logic [KB-1:0]              r_key,        n_key;
    logic [KB-1:0]              r_nkey,       n_nkey;
    logic [SB-1:0]              r_score,      n_score;
    logic [IW-1:0]              r_rd_idx,     n_rd_idx;
    logic [IW-1:0]              r_slot_k,     n_slot_k;
    logic [IW-1:0]              r_slot_nk,    n_slot_nk;
    logic [IW-1:0]              r_free_slot,  n_free_slot;
    ksm_pkg::t_entry            r_top,        n_top;
    logic [IW-1:0]              r_best_idx,   n_best_idx;
    ksm_pkg::t_entry            r_best,       n_best;
    ksm_pkg::t_status           r_status,     n_status;
    logic [ksm_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                       w_wr_en;
    logic [IW-1:0]              w_wr_addr;
    ksm_pkg::t_entry            w_wr_data;
    logic [IW-1:0]              w_rd_addr;
    ksm_pkg::t_entry            w_rd_data;
    ksm_pkg::t_cmp              w_cmp;
    logic                       w_accept;
    logic                       w_scan_more;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_scan_more = (r_idx < (IW + 1)'(ksm_pkg::DEPTH));
    assign w_rd_addr   = w_scan_more ? r_idx[IW-1:0] : '0;

    ksm_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ksm_cmp u_cmp (
        .i_entry   (w_rd_data),
        .i_key     (r_key),
        .i_new_key (r_nkey),
        .i_best    (r_best),
        .o_res     (w_cmp)
    );

    always_comb begin
        logic                 v_rescan;
        logic [IW-1:0]        v_t;
        logic                 v_found;
        logic [IW-1:0]        v_bidx;
        ksm_pkg::t_entry      v_best;
        logic [KB-1:0]        v_out_key;
        logic [SB-1:0]        v_out_score;

        n_state      = r_state;
        n_idx        = r_idx;
        n_live       = r_live;
        n_valid      = r_valid;
        n_count      = r_count;
        n_top_valid  = r_top_valid;
        n_top_idx    = r_top_idx;
        n_hit_k      = r_hit_k;
        n_hit_nk     = r_hit_nk;
        n_free_hit   = r_free_hit;
        n_best_found = r_best_found;
        n_out_valid  = r_out_valid;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_nkey       = r_nkey;
        n_score      = r_score;
        n_rd_idx     = r_rd_idx;
        n_slot_k     = r_slot_k;
        n_slot_nk    = r_slot_nk;
        n_free_slot  = r_free_slot;
        n_top        = r_top;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_status     = r_status;
        n_out_data   = r_out_data;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_slot_k;
        w_wr_data    = '{key: r_key, score: r_score};
        v_rescan     = 1'b0;
        v_t          = r_slot_k;
        v_found      = r_best_found;
        v_bidx       = r_best_idx;
        v_best       = r_best;
        v_out_key    = '0;
        v_out_score  = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd      = ksm_pkg::t_cmd'(s_axis_tdata[ksm_pkg::CMD_W-1:0]);
                    n_key      = s_axis_tdata[ksm_pkg::CMD_W +: KB];
                    n_nkey     = s_axis_tdata[ksm_pkg::CMD_W + KB +: KB];
                    n_score    = s_axis_tdata[ksm_pkg::CMD_W + 2 * KB +: SB];
                    n_idx      = '0;
                    n_live     = 1'b0;
                    n_hit_k    = 1'b0;
                    n_hit_nk   = 1'b0;
                    n_free_hit = 1'b0;
                    n_status   = ksm_pkg::ST_DONE;
                    n_state    = S_FIND;
                end
            end
            S_FIND: begin
                if (r_live) begin
                    if (r_valid[r_rd_idx] && w_cmp.eq_key && !r_hit_k) begin
                        n_hit_k  = 1'b1;
                        n_slot_k = r_rd_idx;
                    end
                    if (r_valid[r_rd_idx] && w_cmp.eq_new_key && !r_hit_nk) begin
                        n_hit_nk  = 1'b1;
                        n_slot_nk = r_rd_idx;
                    end
                    if (!r_valid[r_rd_idx] && !r_free_hit) begin
                        n_free_hit  = 1'b1;
                        n_free_slot = r_rd_idx;
                    end
                end
                if (w_scan_more) begin
                    n_live   = 1'b1;
                    n_rd_idx = r_idx[IW-1:0];
                    n_idx    = r_idx + 1'b1;
                end else begin
                    n_live  = 1'b0;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                unique case (r_cmd)
                    ksm_pkg::CMD_INSERT: begin
                        if (r_hit_k) begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_slot_k;
                            if (r_top_valid && r_slot_k == r_top_idx) begin
                                v_rescan = 1'b1;
                            end else if (!r_top_valid || r_score > r_top.score) begin
                                n_top_valid = 1'b1;
                                n_top_idx   = r_slot_k;
                                n_top       = '{key: r_key, score: r_score};
                            end
                        end else if (!r_free_hit) begin
                            n_status = ksm_pkg::ST_FULL;
                        end else begin
                            w_wr_en              = 1'b1;
                            w_wr_addr            = r_free_slot;
                            n_valid[r_free_slot] = 1'b1;
                            n_count              = r_count + 1'b1;
                            if (!r_top_valid || r_score > r_top.score) begin
                                n_top_valid = 1'b1;
                                n_top_idx   = r_free_slot;
                                n_top       = '{key: r_key, score: r_score};
                            end
                        end
                    end
                    ksm_pkg::CMD_ERASE: begin
                        if (!r_hit_k) begin
                            n_status = ksm_pkg::ST_ABSENT;
                        end else begin
                            n_valid[r_slot_k] = 1'b0;
                            n_count           = r_count - 1'b1;
                            if (r_top_valid && r_slot_k == r_top_idx) begin
                                v_rescan = 1'b1;
                            end
                        end
                    end
                    ksm_pkg::CMD_REPLACE: begin
                        if (!r_hit_k) begin
                            n_status = ksm_pkg::ST_ABSENT;
                        end else begin
                            v_t = r_hit_nk ? r_slot_nk : r_slot_k;
                            if (r_hit_nk && r_slot_nk != r_slot_k) begin
                                n_valid[r_slot_k] = 1'b0;
                                n_count           = r_count - 1'b1;
                            end
                            w_wr_en   = 1'b1;
                            w_wr_addr = v_t;
                            w_wr_data = '{key: r_nkey, score: r_score};
                            // the top pointer may stay on a rewritten entry
                            if (r_top_valid && v_t == r_top_idx) begin
                                n_top = '{key: r_nkey, score: r_score};
                            end
                            if (!r_top_valid || r_score > r_top.score) begin
                                n_top_valid = 1'b1;
                                n_top_idx   = v_t;
                                n_top       = '{key: r_nkey, score: r_score};
                            end else if (r_top_valid && r_slot_k == r_top_idx) begin
                                v_rescan = 1'b1;
                            end
                        end
                    end
                    ksm_pkg::CMD_POP: begin
                        if (!r_top_valid) begin
                            n_status = ksm_pkg::ST_ABSENT;
                        end else begin
                            n_valid[r_top_idx] = 1'b0;
                            n_count            = r_count - 1'b1;
                            v_rescan           = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (v_rescan) begin
                    n_idx        = '0;
                    n_live       = 1'b0;
                    n_best_found = 1'b0;
                    n_state      = S_RESCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RESCAN: begin
                if (r_live && r_valid[r_rd_idx] && (!r_best_found || w_cmp.beats_best)) begin
                    v_found = 1'b1;
                    v_bidx  = r_rd_idx;
                    v_best  = w_rd_data;
                end
                n_best_found = v_found;
                n_best_idx   = v_bidx;
                n_best       = v_best;
                if (w_scan_more) begin
                    n_live   = 1'b1;
                    n_rd_idx = r_idx[IW-1:0];
                    n_idx    = r_idx + 1'b1;
                end else begin
                    n_live      = 1'b0;
                    n_top_valid = v_found;
                    n_top_idx   = v_found ? v_bidx : '0;
                    n_top       = v_best;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    if (r_top_valid) begin
                        v_out_key   = r_top.key;
                        v_out_score = r_top.score;
                    end
                    n_out_data = ksm_pkg::OUT_DATA_W'({r_status, (r_count == '0), r_count,
                                                       v_out_score, v_out_key});
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_live       <= 1'b0;
            r_valid      <= '0;
            r_count      <= '0;
            r_top_valid  <= 1'b0;
            r_top_idx    <= '0;
            r_hit_k      <= 1'b0;
            r_hit_nk     <= 1'b0;
            r_free_hit   <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_live       <= n_live;
            r_valid      <= n_valid;
            r_count      <= n_count;
            r_top_valid  <= n_top_valid;
            r_top_idx    <= n_top_idx;
            r_hit_k      <= n_hit_k;
            r_hit_nk     <= n_hit_nk;
            r_free_hit   <= n_free_hit;
            r_best_found <= n_best_found;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_nkey      <= n_nkey;
        r_score     <= n_score;
        r_rd_idx    <= n_rd_idx;
        r_slot_k    <= n_slot_k;
        r_slot_nk   <= n_slot_nk;
        r_free_slot <= n_free_slot;
        r_top       <= n_top;
        r_best_idx  <= n_best_idx;
        r_best      <= n_best;
        r_status    <= n_status;
        r_out_data  <= n_out_data;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_top_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_top_valid == (r_count != '0)))
        else $error("top flag disagrees with entry count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ksm_pkg::DEPTH))
        else $error("entry count above table depth");

    a_top_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_top_valid) |-> r_valid[r_top_idx])
        else $error("top points at an empty slot");

    a_accept_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_FIND && r_idx == '0))
        else $error("accepted beat did not start a search");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the keyed score table through its command and result streams. A
// table model kept here predicts the top key, top score, entry count, empty
// flag and status of every command. Directed commands cover the empty, full
// and tie cases first. Random traffic follows in phases that fill, mix and
// drain the table, with random gaps on both streams outside the second phase.
// ----------------------------------------------------------------------------

module testbench;

    localparam int DEPTH      = ksm_pkg::DEPTH;
    localparam int KEY_BITS   = ksm_pkg::KEY_BITS;
    localparam int SCORE_BITS = ksm_pkg::SCORE_BITS;
    localparam int CNT_W      = ksm_pkg::CNT_W;
    localparam int IN_BITS    = ksm_pkg::IN_BITS;
    localparam int IN_DATA_W  = ksm_pkg::IN_DATA_W;
    localparam int OUT_BITS   = ksm_pkg::OUT_BITS;
    localparam int OUT_DATA_W = ksm_pkg::OUT_DATA_W;

    typedef struct packed {
        ksm_pkg::t_status      status;
        logic                  is_empty;
        logic [CNT_W-1:0]      count;
        logic [SCORE_BITS-1:0] top_score;
        logic [KEY_BITS-1:0]   top_key;
    } t_table_view;

    localparam int QUIET_LIMIT = 3000;
    localparam int KEY_POOL_N  = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // model of the table contents and the top pointer
    logic [KEY_BITS-1:0]   tbl_key   [DEPTH];
    logic [SCORE_BITS-1:0] tbl_score [DEPTH];
    bit                    tbl_used  [DEPTH];
    int                    top_idx = 0;
    bit                    top_ok = 1'b0;

    t_table_view           pending_views[$];
    logic [KEY_BITS-1:0]   key_pool [KEY_POOL_N];
    bit                    idle_on = 1'b1;
    int                    errors = 0;
    int                    quiet_cycles = 0;

    keyed_score_table_with_max dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // cmd, key, new_key, score, zero pad
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // top_key, top_score, entry_count, is_empty, status
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int slot_of(logic [KEY_BITS-1:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_used[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    // highest score wins, ties go to the lowest key
    function automatic void find_top();
        bit found;
        int best;
        found = 1'b0;
        best = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_used[i] && (!found || tbl_score[i] > tbl_score[best] ||
                (tbl_score[i] == tbl_score[best] && tbl_key[i] < tbl_key[best]))) begin
                best = i;
                found = 1'b1;
            end
        end
        top_ok = found;
        top_idx = found ? best : 0;
    endfunction

    function automatic t_table_view predict_table_view(ksm_pkg::t_cmd c,
                                                       logic [KEY_BITS-1:0] k,
                                                       logic [KEY_BITS-1:0] nk,
                                                       logic [SCORE_BITS-1:0] sc);
        int s;
        int t;
        int n;
        ksm_pkg::t_status st;
        logic [SCORE_BITS-1:0] prev;
        bit old_top;
        t_table_view v;
        st = ksm_pkg::ST_DONE;
        if (top_ok && !tbl_used[top_idx])
            find_top();
        case (c)
            ksm_pkg::CMD_INSERT: begin
                s = slot_of(k);
                if (s >= 0) begin
                    tbl_score[s] = sc;
                    if (top_ok && s == top_idx) begin
                        find_top();
                    end else if (!top_ok || sc > tbl_score[top_idx]) begin
                        top_idx = s;
                        top_ok = 1'b1;
                    end
                end else begin
                    s = -1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!tbl_used[i])
                            s = i;
                    if (s < 0) begin
                        st = ksm_pkg::ST_FULL;
                    end else begin
                        tbl_key[s] = k;
                        tbl_score[s] = sc;
                        tbl_used[s] = 1'b1;
                        if (!top_ok || sc > tbl_score[top_idx]) begin
                            top_idx = s;
                            top_ok = 1'b1;
                        end
                    end
                end
            end
            ksm_pkg::CMD_ERASE: begin
                s = slot_of(k);
                if (s < 0) begin
                    st = ksm_pkg::ST_ABSENT;
                end else begin
                    tbl_used[s] = 1'b0;
                    if (top_ok && s == top_idx)
                        find_top();
                end
            end
            ksm_pkg::CMD_REPLACE: begin
                s = slot_of(k);
                if (s < 0) begin
                    st = ksm_pkg::ST_ABSENT;
                end else begin
                    prev = top_ok ? tbl_score[top_idx] : '0;
                    old_top = top_ok && s == top_idx;
                    t = slot_of(nk);
                    if (t < 0) begin
                        t = s;
                        tbl_key[t] = nk;
                    end else if (t != s) begin
                        tbl_used[s] = 1'b0;
                    end
                    tbl_score[t] = sc;
                    if (!top_ok || sc > prev) begin
                        top_idx = t;
                        top_ok = 1'b1;
                    end else if (old_top) begin
                        find_top();
                    end
                end
            end
            default: begin
                if (!top_ok) begin
                    st = ksm_pkg::ST_ABSENT;
                end else begin
                    tbl_used[top_idx] = 1'b0;
                    find_top();
                end
            end
        endcase
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tbl_used[i])
                n++;
        v.top_key   = top_ok ? tbl_key[top_idx] : '0;
        v.top_score = top_ok ? tbl_score[top_idx] : '0;
        v.count     = n[CNT_W-1:0];
        v.is_empty  = (n == 0);
        v.status    = st;
        return v;
    endfunction

    task automatic send_cmd(ksm_pkg::t_cmd c, logic [KEY_BITS-1:0] k,
                            logic [KEY_BITS-1:0] nk, logic [SCORE_BITS-1:0] sc);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 18)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, sc, nk, k, c};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_views = {pending_views, predict_table_view(c, k, nk, sc)};
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s: got %0h, expected %0h", field, got, want);
        errors++;
    endtask

    function automatic logic [KEY_BITS-1:0] current_top_key();
        return top_ok ? tbl_key[top_idx] : '0;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key();
        return ($urandom_range(0, 9) == 0) ? KEY_BITS'($urandom)
                                           : key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    endfunction

    task automatic test_empty_table();
        send_cmd(ksm_pkg::CMD_POP, '0, '0, '0);
        send_cmd(ksm_pkg::CMD_ERASE, 16'h1234, '0, 32'h1);
        send_cmd(ksm_pkg::CMD_REPLACE, 16'h1234, 16'h0001, 32'h5);
    endtask

    task automatic test_insert_update();
        send_cmd(ksm_pkg::CMD_INSERT, 16'h0000, '0, 32'h0);
        send_cmd(ksm_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // equal score must not take the top
        send_cmd(ksm_pkg::CMD_INSERT, 16'h0005, '0, 32'hFFFF_FFFF);
        // lowering the top forces a rescan
        send_cmd(ksm_pkg::CMD_INSERT, 16'hFFFF, '0, 32'h1);
        send_cmd(ksm_pkg::CMD_INSERT, 16'h0000, '0, 32'h2);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < DEPTH - 3; i++)
            send_cmd(ksm_pkg::CMD_INSERT, KEY_BITS'(16'h0100 + i), '0, $urandom);
        send_cmd(ksm_pkg::CMD_INSERT, 16'h0200, '0, 32'hFFFF_FFFF);
    endtask

    task automatic test_erase_replace();
        send_cmd(ksm_pkg::CMD_ERASE, current_top_key(), '0, '0);
        send_cmd(ksm_pkg::CMD_ERASE, 16'hBEEF, '0, '0);
        send_cmd(ksm_pkg::CMD_REPLACE, 16'h0100, 16'h0101, 32'h3);
        send_cmd(ksm_pkg::CMD_REPLACE, 16'h0102, 16'h0102, 32'hFFFF_FFFF);
        send_cmd(ksm_pkg::CMD_REPLACE, current_top_key(), 16'hA5A5, 32'h0);
        send_cmd(ksm_pkg::CMD_POP, '0, '0, '0);
    endtask

    task automatic test_random_traffic(int beats, int w_ins, int w_era, int w_rep, int w_pop);
        int r;
        ksm_pkg::t_cmd c;
        logic [KEY_BITS-1:0] k;
        logic [SCORE_BITS-1:0] sc;
        for (int n = 0; n < beats; n++) begin
            r = $urandom_range(0, w_ins + w_era + w_rep + w_pop - 1);
            if (r < w_ins)
                c = ksm_pkg::CMD_INSERT;
            else if (r < w_ins + w_era)
                c = ksm_pkg::CMD_ERASE;
            else if (r < w_ins + w_era + w_rep)
                c = ksm_pkg::CMD_REPLACE;
            else
                c = ksm_pkg::CMD_POP;
            k = pick_key();
            if (c != ksm_pkg::CMD_INSERT && top_ok && $urandom_range(0, 2) == 0)
                k = current_top_key();
            r = $urandom_range(0, 9);
            if (r < 3)
                sc = $urandom_range(0, 7);
            else if (r == 3)
                sc = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF - $urandom_range(0, 1);
            else
                sc = $urandom;
            send_cmd(c, k, pick_key(), sc);
        end
    endtask

    always @(posedge i_clk)
        m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 18);

    always @(posedge i_clk) begin : check_results
        t_table_view got;
        t_table_view want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[OUT_BITS-1:0];
            if (pending_views.size() == 0) begin
                report_mismatch("unexpected beat", 64'(m_axis_tdata), '0);
            end else begin
                want = pending_views.pop_front();
                if (got.top_key !== want.top_key)
                    report_mismatch("top_key", 64'(got.top_key), 64'(want.top_key));
                if (got.top_score !== want.top_score)
                    report_mismatch("top_score", 64'(got.top_score), 64'(want.top_score));
                if (got.count !== want.count)
                    report_mismatch("entry_count", 64'(got.count), 64'(want.count));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** keyed_score_table_with_max: FAILED **");
            $finish;
        end
    end

    initial begin
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        key_pool[2] = 16'h5555;
        key_pool[3] = 16'hAAAA;
        for (int i = 4; i < KEY_POOL_N; i++)
            key_pool[i] = KEY_BITS'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_insert_update();
        test_full_table();
        test_erase_replace();
        test_random_traffic(160, 70, 10, 10, 10);
        idle_on <= 1'b0;
        test_random_traffic(160, 35, 20, 25, 20);
        idle_on <= 1'b1;
        test_random_traffic(150, 15, 35, 20, 30);
        test_random_traffic(150, 40, 15, 30, 15);
        s_axis_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge i_clk);
        repeat (48) @(posedge i_clk);
        if (errors == 0)
            $display("** keyed_score_table_with_max: PASSED **");
        else
            $display("** keyed_score_table_with_max: FAILED **");
        $finish;
    end

endmodule
